@@ rtl/itoa_pkg.sv @@
// Shared types, constants and a helper function for the integer to ASCII converter.
package itoa_pkg;

  // Default depth of the digit store.
  localparam int MAX_DIGITS_DEF = 32;

  // Radix register width, reset value and legal range.
  localparam int          RADIX_W     = 5;
  localparam logic [4:0]  RADIX_RESET = 5'd10;
  localparam logic [4:0]  RADIX_MIN   = 5'd2;
  localparam logic [4:0]  RADIX_MAX   = 5'd16;

  // Character codes.
  localparam logic [7:0]  CHAR_MINUS    = 8'd45;
  localparam logic [7:0]  DIGIT_OFFSET  = 8'd48;
  localparam logic [7:0]  LETTER_OFFSET = 8'd55;
  localparam logic [7:0]  CHAR_NONE     = 8'd0;

  // Input value width, division step size and count, and text length width.
  localparam int VALUE_W  = 32;
  localparam int CHUNK_W  = 8;
  localparam int STEPS    = VALUE_W / CHUNK_W;
  localparam int STEP_W   = $clog2(STEPS);
  localparam int LEN_W    = 6;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ERR,
    ST_DIV,
    ST_SIGN,
    ST_READ,
    ST_EMIT
  } itoa_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic start;
    logic div_step;
    logic sign_load;
    logic dig_load;
    logic err_load;
  } itoa_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic radix_ok;
    logic div_last;
    logic neg;
    logic idx_zero;
    logic out_free;
  } itoa_status_t;

  // Map one digit value to its uppercase ASCII character.
  function automatic logic [7:0] digit_char(input logic [3:0] d);
    logic [7:0] wide;
    wide = {4'd0, d};
    if (d > 4'd9) begin
      digit_char = wide + LETTER_OFFSET;
    end else begin
      digit_char = wide + DIGIT_OFFSET;
    end
  endfunction

endpackage

@@ rtl/itoa_ctrl.sv @@
// Controller state machine that sequences division and character emission.
module itoa_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  itoa_pkg::itoa_status_t status,
  output itoa_pkg::itoa_cmd_t    cmd
);
  import itoa_pkg::*;

  itoa_state_t state_r, state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = status.radix_ok ? ST_DIV : ST_ERR;
        end
      end
      ST_ERR: begin
        if (status.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_DIV: begin
        if (status.div_last) begin
          state_nxt = status.neg ? ST_SIGN : ST_READ;
        end
      end
      ST_SIGN: begin
        if (status.out_free) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (status.out_free) begin
          state_nxt = status.idx_zero ? ST_IDLE : ST_READ;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Outputs. The input stays stalled while reset is held.
  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        in_stall  = !rst_n;
        cmd.start = in_valid && rst_n && status.radix_ok;
      end
      ST_ERR: begin
        cmd.err_load = status.out_free;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
      end
      ST_SIGN: begin
        cmd.sign_load = status.out_free;
      end
      ST_READ: begin
        cmd = '0;
      end
      ST_EMIT: begin
        cmd.dig_load = status.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

@@ rtl/itoa_dp.sv @@
// Datapath: radix register, digit divider, digit store and output register.
module itoa_dp #(
  parameter int MAX_DIGITS = itoa_pkg::MAX_DIGITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [4:0]            cfg_wr_data,
  input  logic signed [31:0]    in_value,
  input  itoa_pkg::itoa_cmd_t    cmd,
  output itoa_pkg::itoa_status_t status,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [7:0]            out_char_code,
  output logic                  out_is_last,
  output logic                  out_bad_radix,
  output logic [5:0]            out_text_length
);
  import itoa_pkg::*;

  localparam int AW    = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam int CNT_W = $clog2(MAX_DIGITS + 1);
  localparam int TOT_W = (CNT_W + 1 > LEN_W) ? CNT_W + 1 : LEN_W;

  logic [RADIX_W-1:0] radix_r;
  logic [VALUE_W-1:0] mag_r, mag_nxt;
  logic [3:0]         rem_r, rem_nxt;
  logic [STEP_W-1:0]  step_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [AW-1:0]      idx_r;
  logic               neg_r;
  logic [3:0]         mem [MAX_DIGITS];
  logic [3:0]         mem_q;
  logic [7:0]         qbyte;
  logic               step_last;
  logic [VALUE_W-1:0] raw;
  logic [TOT_W-1:0]   total;
  logic               out_valid_r;
  logic [7:0]         char_r;
  logic               last_r;
  logic               bad_r;
  logic [5:0]         len_r;

  // Radix configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r <= RADIX_RESET;
    end else if (cfg_wr_en) begin
      radix_r <= cfg_wr_data;
    end
  end

  // One quotient byte per cycle by restoring long division on a narrow remainder.
  always_comb begin
    logic [4:0] r;
    r = {1'b0, rem_r};
    qbyte = '0;
    for (int j = CHUNK_W - 1; j >= 0; j--) begin
      r = {r[3:0], mag_r[VALUE_W - CHUNK_W + j]};
      if (r >= radix_r) begin
        r = r - radix_r;
        qbyte[j] = 1'b1;
      end
    end
    rem_nxt = r[3:0];
    mag_nxt = {mag_r[VALUE_W-CHUNK_W-1:0], qbyte};
  end

  assign step_last = (step_r == STEP_W'(STEPS - 1));
  assign raw       = in_value;

  // Division state: sign, magnitude, partial remainder, step and digit counters, read index.
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      neg_r  <= raw[VALUE_W-1];
      mag_r  <= raw[VALUE_W-1] ? (~raw + VALUE_W'(1)) : raw;
      rem_r  <= '0;
      step_r <= '0;
      cnt_r  <= '0;
    end else if (cmd.div_step) begin
      mag_r  <= mag_nxt;
      step_r <= step_r + STEP_W'(1);
      if (step_last) begin
        rem_r <= '0;
        cnt_r <= cnt_r + CNT_W'(1);
        idx_r <= cnt_r[AW-1:0];
      end else begin
        rem_r <= rem_nxt;
      end
    end else if (cmd.dig_load) begin
      idx_r <= idx_r - AW'(1);
    end
  end

  // Digit store, least significant digit at the lowest address.
  always_ff @(posedge clk) begin
    if (cmd.div_step && step_last) begin
      mem[cnt_r[AW-1:0]] <= rem_nxt;
    end
    mem_q <= mem[idx_r];
  end

  assign total = TOT_W'(cnt_r) + TOT_W'(neg_r);

  // Output register; it frees when its transaction is taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.sign_load || cmd.dig_load || cmd.err_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output payload.
  always_ff @(posedge clk) begin
    if (cmd.err_load) begin
      char_r <= CHAR_NONE;
      last_r <= 1'b1;
      bad_r  <= 1'b1;
      len_r  <= '0;
    end else if (cmd.sign_load) begin
      char_r <= CHAR_MINUS;
      last_r <= 1'b0;
      bad_r  <= 1'b0;
      len_r  <= '0;
    end else if (cmd.dig_load) begin
      char_r <= digit_char(mem_q);
      last_r <= (idx_r == '0);
      bad_r  <= 1'b0;
      len_r  <= (idx_r == '0) ? total[LEN_W-1:0] : '0;
    end
  end

  // Status toward the controller.
  assign status.radix_ok = (radix_r >= RADIX_MIN) && (radix_r <= RADIX_MAX);
  assign status.div_last = cmd.div_step && step_last &&
                           ((mag_nxt == '0) || (cnt_r == CNT_W'(MAX_DIGITS - 1)));
  assign status.neg      = neg_r;
  assign status.idx_zero = (idx_r == '0);
  assign status.out_free = !out_valid_r || !out_stall;

  assign out_valid       = out_valid_r;
  assign out_char_code   = char_r;
  assign out_is_last     = last_r;
  assign out_bad_radix   = bad_r;
  assign out_text_length = len_r;

endmodule

@@ rtl/integer_to_ascii_radix.sv @@
// Top level of the integer to ASCII text converter, radix 2 to 16.
//
// Converts one signed 32-bit value per transaction into its text in the radix
// held in the cfg register (reset 10), one character per output transaction,
// most significant digit first, with a leading '-' for negative values and
// uppercase A-F. The last character carries the total length. A radix outside
// 2..16 gives a single result with bad_radix set and length 0. One conversion
// is in flight at a time: the input is accepted, then the divider produces each
// digit in 8-bit quotient chunks (one chunk per cycle against the radix), then
// each digit character is read from the digit store and then loaded into the
// output register, while the sign goes straight into the output register.
// Characters wait in the output register while out_stall is high.
// Configure the radix only while no conversion is in progress.
module integer_to_ascii_radix #(
  parameter int MAX_DIGITS = itoa_pkg::MAX_DIGITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [4:0]         cfg_wr_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] in_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         out_char_code,
  output logic               out_is_last,
  output logic               out_bad_radix,
  output logic [5:0]         out_text_length
);
  import itoa_pkg::*;

  itoa_cmd_t    cmd;
  itoa_status_t status;

  // Sequencer.
  itoa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // Divider, digit store and output stage.
  itoa_dp #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_value        (in_value),
    .cmd             (cmd),
    .status          (status),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_char_code   (out_char_code),
    .out_is_last     (out_is_last),
    .out_bad_radix   (out_bad_radix),
    .out_text_length (out_text_length)
  );

endmodule

@@ verif/integer_to_ascii_radix_checker.sv @@
// Checker that predicts and compares the character stream of the integer to ASCII converter.
`timescale 1ns / 100ps
module integer_to_ascii_radix_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [4:0]         cfg_wr_data,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic signed [31:0] in_value,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [7:0]         out_char_code,
  input  logic               out_is_last,
  input  logic               out_bad_radix,
  input  logic [5:0]         out_text_length,
  output int                 fail_count,
  output int                 pending
);
  import itoa_pkg::*;

  // One character of converted text, as the block should present it.
  typedef struct packed {
    logic [7:0]       char_code;
    logic             is_last;
    logic             bad_radix;
    logic [LEN_W-1:0] text_length;
  } text_char_t;

  text_char_t         expected_text[$];
  logic [RADIX_W-1:0] base_reg = RADIX_RESET;
  int                 mismatches = 0;

  // Queue the characters that one accepted value turns into under the current base.
  task automatic predict_text(input logic [31:0] value);
    logic [31:0] magnitude;
    logic [31:0] base;
    logic [3:0]  digit_vals [32];
    logic [7:0]  wide;
    int          ndig;
    logic        negative;
    text_char_t  entry;
    entry = '0;
    if (base_reg < RADIX_MIN || base_reg > RADIX_MAX) begin
      // An illegal base yields a single error character and nothing else.
      entry.char_code   = CHAR_NONE;
      entry.is_last     = 1'b1;
      entry.bad_radix   = 1'b1;
      entry.text_length = '0;
      expected_text.push_back(entry);
      return;
    end
    base      = {27'd0, base_reg};
    negative  = value[31];
    magnitude = negative ? (32'd0 - value) : value;
    ndig      = 0;
    do begin
      digit_vals[ndig] = 4'(magnitude % base);
      magnitude        = magnitude / base;
      ndig++;
    end while (magnitude != 0 && ndig < 32);
    if (negative) begin
      entry.char_code = CHAR_MINUS;
      expected_text.push_back(entry);
    end
    // Digits go out most significant first; only the final one carries the length.
    for (int i = ndig - 1; i >= 0; i--) begin
      wide            = {4'd0, digit_vals[i]};
      entry.char_code = (digit_vals[i] < 4'd10) ? wide + DIGIT_OFFSET : wide + LETTER_OFFSET;
      entry.is_last   = (i == 0);
      entry.bad_radix = 1'b0;
      entry.text_length = (i == 0) ? LEN_W'(ndig + (negative ? 1 : 0)) : '0;
      expected_text.push_back(entry);
    end
  endtask

  // Watch both channels and the register port at every edge.
  always @(posedge clk) begin
    text_char_t want;
    text_char_t got;
    if (!rst_n) begin
      base_reg = RADIX_RESET;
      expected_text.delete();
    end else begin
      // Compare each result transaction with the oldest prediction.
      if (out_valid && !out_stall) begin
        got.char_code   = out_char_code;
        got.is_last     = out_is_last;
        got.bad_radix   = out_bad_radix;
        got.text_length = out_text_length;
        if (expected_text.size() == 0) begin
          $display("%0t: unexpected result: char %h last %b bad %b len %0d", $time,
                   got.char_code, got.is_last, got.bad_radix, got.text_length);
          mismatches++;
        end else begin
          want = expected_text.pop_front();
          if (got.char_code !== want.char_code || got.is_last !== want.is_last ||
              got.bad_radix !== want.bad_radix || got.text_length !== want.text_length) begin
            $display({"%0t: mismatch: expected char %h last %b bad %b len %0d,",
                      " got char %h last %b bad %b len %0d"},
                     $time, want.char_code, want.is_last, want.bad_radix, want.text_length,
                     got.char_code, got.is_last, got.bad_radix, got.text_length);
            mismatches++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        predict_text(in_value);
      end
      if (cfg_wr_en) begin
        base_reg = cfg_wr_data;
      end
    end
    pending    <= expected_text.size();
    fail_count <= mismatches;
  end

endmodule

@@ verif/integer_to_ascii_radix_tb.sv @@
// Stimulus and verdict for the integer to ASCII converter testbench.
`timescale 1ns / 100ps
module integer_to_ascii_radix_tb;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_wr_en = 1'b0;
  logic [4:0]         cfg_wr_data = 5'd0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic signed [31:0] in_value = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [7:0]         out_char_code;
  logic               out_is_last;
  logic               out_bad_radix;
  logic [5:0]         out_text_length;
  int                 fail_count;
  int                 pending;

  // Flow control requests set by the stimulus for the sender and the result sink.
  bit                 hold_req = 1'b0;
  bit                 tx_eager = 1'b0;
  bit                 rx_eager = 1'b0;

  integer_to_ascii_radix uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_char_code   (out_char_code),
    .out_is_last     (out_is_last),
    .out_bad_radix   (out_bad_radix),
    .out_text_length (out_text_length)
  );

  integer_to_ascii_radix_checker text_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_char_code   (out_char_code),
    .out_is_last     (out_is_last),
    .out_bad_radix   (out_bad_radix),
    .out_text_length (out_text_length),
    .fail_count      (fail_count),
    .pending         (pending)
  );

  // 20 ns clock.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Offer one value after a random gap (none when tx_eager is set) and hold it until the transaction completes.
  task automatic send_value(input logic [31:0] value);
    int gap;
    gap = tx_eager ? 0 : $urandom_range(0, 15);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_value <= value;
    do @(posedge clk); while (in_stall);
  endtask

  // Stop offering and wait until every predicted character has been delivered.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic set_radix(input logic [4:0] base);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= base;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // Mix of full-range, small and shifted magnitudes of both signs.
  function automatic logic [31:0] random_value();
    logic [31:0] v;
    case ($urandom_range(0, 4))
      0:       v = $urandom;
      1:       v = $urandom_range(0, 40);
      2:       v = 32'd0 - $urandom_range(1, 40);
      3:       v = $urandom >> $urandom_range(0, 31);
      default: v = 32'd0 - ($urandom >> $urandom_range(0, 31));
    endcase
    return v;
  endfunction

  // Result sink: random stalls per transaction, none when rx_eager is set, one long hold on request.
  initial begin : result_sink
    int hold;
    forever begin
      if (hold_req) begin
        hold     = 400;
        hold_req = 1'b0;
      end else if (rx_eager) begin
        hold = 0;
      end else begin
        hold = $urandom_range(0, 15);
      end
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (out_valid !== 1'b1);
    end
  end

  // Stimulus: directed corners first, then random phases under varied bases.
  initial begin : stimulus
    logic [4:0] base;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Decimal at the reset value, including zero and both extremes.
    send_value(32'd0);
    send_value(32'd1);
    send_value(32'hFFFF_FFFF);
    send_value(32'd9);
    send_value(32'd10);
    send_value(32'hFFFF_FFF6);
    send_value(32'h7FFF_FFFF);
    send_value(32'h8000_0000);
    wait_drained();

    // Hex exercises the letter digits.
    set_radix(5'd16);
    send_value(32'h0ABC_DEF0);
    send_value(32'hFEDC_BA98);
    send_value(32'h89AB_CDEF);
    wait_drained();

    // Binary gives the longest text, a sign and 32 digits.
    set_radix(5'd2);
    send_value(32'h8000_0000);
    send_value(32'h7FFF_FFFF);
    send_value(32'd5);
    wait_drained();
    set_radix(5'd3);
    send_value(32'h8000_0000);
    wait_drained();
    set_radix(5'd7);
    send_value(32'hFFFF_CFC7);
    wait_drained();

    // Illegal bases on both sides of the legal range.
    set_radix(5'd0);
    send_value(32'h1234_5678);
    wait_drained();
    set_radix(5'd1);
    send_value(32'hFFFF_FFFF);
    wait_drained();
    set_radix(5'd17);
    send_value(32'd42);
    wait_drained();
    set_radix(5'd31);
    send_value(32'h8000_0000);
    wait_drained();

    // Random phases, each under one base written while the block is idle.
    for (int phase = 0; phase < 9; phase++) begin
      case (phase)
        0:       base = 5'd2;
        1:       base = 5'd16;
        2:       base = 5'd10;
        default: begin
          if ($urandom_range(0, 9) == 0) begin
            base = $urandom_range(0, 1) ? 5'($urandom_range(0, 1)) : 5'($urandom_range(17, 31));
          end else begin
            base = 5'($urandom_range(2, 16));
          end
        end
      endcase
      set_radix(base);
      // Phase 4 holds the output off while the sender keeps pushing; phase 6 runs flat out.
      tx_eager = (phase == 4 || phase == 6);
      rx_eager = (phase == 6);
      if (phase == 4) begin
        hold_req = 1'b1;
      end
      for (int n = 0; n < 10; n++) begin
        send_value(random_value());
      end
      wait_drained();
      tx_eager = 1'b0;
      rx_eager = 1'b0;
    end

    // Allow for any stray output after the last conversion.
    repeat (250) @(posedge clk);
    if (fail_count == 0) begin
      $display("integer_to_ascii_radix_tb: PASS");
    end else begin
      $display("integer_to_ascii_radix_tb: FAIL");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin : watchdog
    #20_000_000;
    $display("integer_to_ascii_radix_tb: FAIL");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/itoa_pkg.sv
rtl/itoa_ctrl.sv
rtl/itoa_dp.sv
rtl/integer_to_ascii_radix.sv
verif/integer_to_ascii_radix_checker.sv
verif/integer_to_ascii_radix_tb.sv
